@@ rtl/ovlt_pkg.sv @@
package ovlt_pkg;

   localparam int OVLT_CAPACITY = 64;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 1;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT   = 2'd0;
   localparam cmd_type CMD_REMOVE   = 2'd1;
   localparam cmd_type CMD_CONTAINS = 2'd2;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_REFUSED = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SORTED_MODE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOW_DUPLICATES = 1'd1;

endpackage

@@ rtl/ovlt_req_if.sv @@
interface ovlt_req_if
   import ovlt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   cmd_type                   cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

@@ rtl/ovlt_rsp_if.sv @@
interface ovlt_rsp_if
   import ovlt_pkg::*;
   #(parameter int CNT_W = $clog2(OVLT_CAPACITY + 1))
   ();
   logic             valid;
   logic             ready;
   status_type       status;
   logic             is_empty;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, status, is_empty, entry_count, input ready);
   modport sink   (input valid, status, is_empty, entry_count, output ready);
endinterface

@@ rtl/ordered_value_list_table.sv @@
// A command on an empty table goes straight to the result, an insert into it
// through the room check and a single write. Otherwise the entries are walked
// (one store read, then one compare or write-back, per entry), except for an
// insert with duplicates allowed in unsorted mode; an insert that opens a gap
// then moves each entry above it up one slot with one read and one write.
// Throughput: one command at a time; the result sits in an output register, so
// the next command is taken while it waits. Reset (synchronous) empties the
// table and clears both mode registers; entry contents are not cleared.
module ordered_value_list_table
   import ovlt_pkg::*;
   #(parameter int CAPACITY = OVLT_CAPACITY,
     parameter int CNT_W    = $clog2(CAPACITY + 1))
   (
   input  logic                  clock,
   input  logic                  reset,
   ovlt_req_if.sink              req_ch,
   ovlt_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
   );

   localparam int AW = $clog2(CAPACITY);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRD  = 3'd1;
   localparam logic [2:0] S_SEX  = 3'd2;
   localparam logic [2:0] S_ICHK = 3'd3;
   localparam logic [2:0] S_SHRD = 3'd4;
   localparam logic [2:0] S_SHWR = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]                state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          wr_ff, wr_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      stop_ff, stop_in;
   logic                      found_ff, found_in;
   status_type                status_ff, status_in;
   logic                      sorted_ff, dup_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   logic [VALUE_W-1:0]        mem [CAPACITY];
   logic [VALUE_W-1:0]        rdata_ff;
   logic                      mem_re, mem_we;
   logic [AW-1:0]             mem_raddr, mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;

   logic                      req_xfer, eq, gt, last, stop_gt, drop;
   logic [CNT_W-1:0]          idx_prev;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.is_empty    = rsp_empty_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   assign eq       = (rdata_ff == val_ff);
   assign gt       = ($signed(rdata_ff) > val_ff);
   assign last     = ((idx_ff + CNT_W'(1)) == count_ff);
   assign stop_gt  = dup_ff && sorted_ff && gt;
   assign drop     = !stop_ff && !stop_gt && eq;
   assign idx_prev = idx_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      stop_in       = stop_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_raddr     = idx_ff[AW-1:0];
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = rdata_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_ch.cmd;
               val_in   = req_ch.value;
               idx_in   = '0;
               wr_in    = '0;
               pos_in   = '0;
               stop_in  = 1'b0;
               found_in = 1'b0;
               case (req_ch.cmd)
                  CMD_INSERT: begin
                     if (count_ff == '0 || (!sorted_ff && dup_ff)) begin
                        state_in = S_ICHK;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  CMD_REMOVE, CMD_CONTAINS: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_REFUSED;
                        state_in  = S_FIN;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  default: begin
                     status_in = STATUS_REFUSED;
                     state_in  = S_FIN;
                  end
               endcase
            end
         end
         S_SRD: begin
            mem_re   = 1'b1;
            state_in = S_SEX;
         end
         S_SEX: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  if (sorted_ff && gt) begin
                     pos_in   = idx_ff;
                     state_in = S_ICHK;
                  end else if (eq && !dup_ff) begin
                     status_in = STATUS_REFUSED;
                     state_in  = S_FIN;
                  end else if (last) begin
                     pos_in   = sorted_ff ? count_ff : '0;
                     state_in = S_ICHK;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_SRD;
                  end
               end
               CMD_REMOVE: begin
                  // compact in place: kept entries move down to the write pointer
                  if (stop_gt) begin
                     stop_in = 1'b1;
                  end
                  if (drop) begin
                     found_in = 1'b1;
                     if (!dup_ff) begin
                        stop_in = 1'b1;
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = wr_ff[AW-1:0];
                     wr_in     = wr_ff + CNT_W'(1);
                  end
                  if (last) begin
                     count_in  = drop ? wr_ff : wr_ff + CNT_W'(1);
                     status_in = (drop || found_ff) ? STATUS_DONE : STATUS_REFUSED;
                     state_in  = S_FIN;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_SRD;
                  end
               end
               CMD_CONTAINS: begin
                  if (eq) begin
                     status_in = STATUS_DONE;
                     state_in  = S_FIN;
                  end else if (last) begin
                     status_in = STATUS_REFUSED;
                     state_in  = S_FIN;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = S_SRD;
                  end
               end
               default: begin
                  status_in = STATUS_REFUSED;
                  state_in  = S_FIN;
               end
            endcase
         end
         S_ICHK: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = STATUS_FULL;
               state_in  = S_FIN;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            // shift entries up one slot, from the tail down to the gap
            if (idx_ff == pos_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = val_ff;
               count_in  = count_ff + CNT_W'(1);
               status_in = STATUS_DONE;
               state_in  = S_FIN;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_prev[AW-1:0];
               state_in  = S_SHWR;
            end
         end
         S_SHWR: begin
            mem_we   = 1'b1;
            idx_in   = idx_prev;
            state_in = S_SHRD;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         stop_ff      <= 1'b0;
         found_ff     <= 1'b0;
         sorted_ff    <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         stop_ff      <= stop_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == REG_SORTED_MODE) begin
            sorted_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == REG_ALLOW_DUPLICATES) begin
            dup_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      wr_ff         <= wr_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> count_ff == $past(count_ff))
      else $error("entry count changed while idle");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside the finish step");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_count_ff == CNT_W'(CAPACITY))
      else $error("full status with spare room");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHRD |-> idx_ff < CNT_W'(CAPACITY) && pos_ff <= idx_ff)
      else $error("shift pointer out of range");

endmodule
